@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define PRL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PRL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/prl_pkg.sv @@
`timescale 1ns / 1ps

package prl_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;

	localparam int CNT_W  = 16;
	localparam int TIME_W = 32;
	localparam int SPAN_W = 31;
	localparam int SLOT_W = 6;

	localparam logic [CNT_W-1:0]  THRESHOLD_RST = 16'd100;
	localparam logic [SPAN_W-1:0] WINDOW_RST    = 31'd6000;
	localparam logic [SPAN_W-1:0] BLOCK_RST     = 31'd6000;

	localparam logic CMD_PACKET = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_WINDOW    = 2'd1;
	localparam logic [1:0] REG_BLOCK     = 2'd2;

	typedef enum logic [1:0] {
		VERDICT_KNOWN = 2'd0,
		VERDICT_NEW   = 2'd1,
		VERDICT_FULL  = 2'd2,
		VERDICT_DROP  = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [CNT_W-1:0]  count_threshold;
		logic [SPAN_W-1:0] window_ticks;
		logic [SPAN_W-1:0] block_ticks;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0] addr;
		logic [TIME_W-1:0] last_time;
		logic [CNT_W-1:0]  count;
		logic              blocked;
		logic [TIME_W-1:0] unblock_time;
	} entry_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

@@ design/prl_alu.sv @@
`timescale 1ns / 1ps

module prl_alu (
	input  logic [prl_pkg::TIME_W-1:0] a,
	input  logic [prl_pkg::TIME_W-1:0] b,
	input  logic                       sub,
	output logic [prl_pkg::TIME_W-1:0] sum
);

	logic [prl_pkg::TIME_W-1:0] b_op;

	// subtract as a plus inverted b plus one
	assign b_op = sub ? ~b : b;
	assign sum  = prl_pkg::TIME_W'(a + b_op + {{(prl_pkg::TIME_W-1){1'b0}}, sub});

endmodule

@@ design/prl_table.sv @@
`timescale 1ns / 1ps

module prl_table #(
	parameter int TABLE_ENTRIES = prl_pkg::TABLE_ENTRIES_DEF,
	localparam int IW = $clog2(TABLE_ENTRIES)
) (
	input  logic               clk,
	input  prl_pkg::mem_ctl_t  ctl,
	input  logic [IW-1:0]      waddr,
	input  prl_pkg::entry_t    wdata,
	input  logic [IW-1:0]      raddr,
	output prl_pkg::entry_t    rdata
);

	prl_pkg::entry_t mem_q [TABLE_ENTRIES];
	prl_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/prl_seq.sv @@
`timescale 1ns / 1ps

module prl_seq #(
	parameter int TABLE_ENTRIES = prl_pkg::TABLE_ENTRIES_DEF,
	localparam int IW = $clog2(TABLE_ENTRIES)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        command,
	input  logic [31:0]                 src_addr,
	input  prl_pkg::cfg_t               cfg,
	output logic                        busy,
	output logic                        done,
	output logic [1:0]                  verdict,
	output logic                        blocked_now,
	output logic [prl_pkg::SLOT_W-1:0]  entry_slot,
	output prl_pkg::mem_ctl_t           mem_ctl,
	output logic [IW-1:0]               mem_waddr,
	output prl_pkg::entry_t             mem_wdata,
	output logic [IW-1:0]               mem_raddr,
	input  prl_pkg::entry_t             mem_rdata,
	output logic [prl_pkg::TIME_W-1:0]  alu_a,
	output logic [prl_pkg::TIME_W-1:0]  alu_b,
	output logic                        alu_sub,
	input  logic [prl_pkg::TIME_W-1:0]  alu_sum
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHK_UNBLK,
		ST_ADD_WIN,
		ST_CHK_WIN,
		ST_COUNT,
		ST_ADD_BLK,
		ST_WRITE
	} state_t;

	localparam logic [IW:0] FULL_CNT = (IW+1)'(TABLE_ENTRIES);

	state_t                      state_q;
	logic [31:0]                 addr_q;
	logic [prl_pkg::TIME_W-1:0]  now_q;
	logic [IW:0]                 fill_q;
	logic [IW:0]                 scan_q;
	logic [IW-1:0]               cmp_idx_q;
	logic                        cmp_vld_q;
	logic [IW-1:0]               slot_q;
	prl_pkg::entry_t             ent_q;
	logic [prl_pkg::TIME_W-1:0]  sum_q;
	logic                        blk_q;
	logic                        done_q;
	prl_pkg::verdict_t           verdict_q;
	logic                        blocked_now_q;
	logic [prl_pkg::SLOT_W-1:0]  slot_out_q;

	logic                        hit;
	logic [prl_pkg::CNT_W-1:0]   cnt_inc;
	prl_pkg::entry_t             new_ent;

	assign hit     = cmp_vld_q && (mem_rdata.addr == addr_q);
	assign cnt_inc = (ent_q.count != {prl_pkg::CNT_W{1'b1}}) ?
		prl_pkg::CNT_W'(ent_q.count + 1'b1) : ent_q.count;

	always_comb begin
		new_ent              = '0;
		new_ent.addr         = addr_q;
		new_ent.last_time    = now_q;
		new_ent.count        = prl_pkg::CNT_W'(1);
	end

	// one issued read per cycle, compared in the cycle after it is issued
	always_comb begin
		mem_ctl       = '0;
		mem_ctl.rd_en = (state_q == ST_SCAN) && (scan_q != fill_q);
		mem_raddr     = scan_q[IW-1:0];
		mem_waddr     = slot_q;
		mem_wdata     = ent_q;
		if (state_q == ST_WRITE) begin
			mem_ctl.wr_en       = 1'b1;
			mem_wdata.last_time = now_q;
		end else if (state_q == ST_SCAN && !hit && scan_q == fill_q && fill_q != FULL_CNT) begin
			mem_ctl.wr_en = 1'b1;
			mem_waddr     = fill_q[IW-1:0];
			mem_wdata     = new_ent;
		end
	end

	// operands for the shared adder
	always_comb begin
		alu_a   = now_q;
		alu_b   = prl_pkg::TIME_W'(1);
		alu_sub = 1'b0;
		case (state_q)
			ST_CHK_UNBLK: begin
				alu_b   = ent_q.unblock_time;
				alu_sub = 1'b1;
			end
			ST_ADD_WIN: begin
				alu_a = ent_q.last_time;
				alu_b = {1'b0, cfg.window_ticks};
			end
			ST_CHK_WIN: begin
				alu_a   = sum_q;
				alu_b   = now_q;
				alu_sub = 1'b1;
			end
			ST_ADD_BLK: begin
				alu_b = {1'b0, cfg.block_ticks};
			end
			default: begin
				alu_b = prl_pkg::TIME_W'(1);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			now_q         <= '0;
			fill_q        <= '0;
			scan_q        <= '0;
			cmp_vld_q     <= 1'b0;
			done_q        <= 1'b0;
			verdict_q     <= prl_pkg::VERDICT_KNOWN;
			blocked_now_q <= 1'b0;
			slot_out_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (command == prl_pkg::CMD_TICK) begin
							now_q <= alu_sum;
						end else begin
							addr_q    <= src_addr;
							scan_q    <= '0;
							cmp_vld_q <= 1'b0;
							blk_q     <= 1'b0;
							state_q   <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					cmp_vld_q <= mem_ctl.rd_en;
					cmp_idx_q <= scan_q[IW-1:0];
					if (mem_ctl.rd_en) begin
						scan_q <= scan_q + 1'b1;
					end
					if (hit) begin
						ent_q   <= mem_rdata;
						slot_q  <= cmp_idx_q;
						state_q <= ST_CHK_UNBLK;
					end else if (scan_q == fill_q) begin
						done_q        <= 1'b1;
						blocked_now_q <= 1'b0;
						state_q       <= ST_IDLE;
						if (fill_q != FULL_CNT) begin
							fill_q     <= fill_q + 1'b1;
							verdict_q  <= prl_pkg::VERDICT_NEW;
							slot_out_q <= prl_pkg::SLOT_W'(fill_q[IW-1:0]);
						end else begin
							verdict_q  <= prl_pkg::VERDICT_FULL;
							slot_out_q <= '0;
						end
					end
				end
				ST_CHK_UNBLK: begin
					// sign clear means the unblock time is reached
					if (ent_q.blocked && alu_sum[prl_pkg::TIME_W-1]) begin
						done_q        <= 1'b1;
						verdict_q     <= prl_pkg::VERDICT_DROP;
						blocked_now_q <= 1'b0;
						slot_out_q    <= prl_pkg::SLOT_W'(slot_q);
						state_q       <= ST_IDLE;
					end else begin
						ent_q.blocked <= 1'b0;
						state_q       <= ST_ADD_WIN;
					end
				end
				ST_ADD_WIN: begin
					sum_q   <= alu_sum;
					state_q <= ST_CHK_WIN;
				end
				ST_CHK_WIN: begin
					// gap beyond the window restarts the count
					if (alu_sum[prl_pkg::TIME_W-1]) begin
						ent_q.count <= prl_pkg::CNT_W'(1);
						state_q     <= ST_WRITE;
					end else begin
						state_q <= ST_COUNT;
					end
				end
				ST_COUNT: begin
					ent_q.count <= cnt_inc;
					if (cnt_inc >= cfg.count_threshold) begin
						ent_q.blocked <= 1'b1;
						blk_q         <= 1'b1;
						state_q       <= ST_ADD_BLK;
					end else begin
						state_q <= ST_WRITE;
					end
				end
				ST_ADD_BLK: begin
					ent_q.unblock_time <= alu_sum;
					state_q            <= ST_WRITE;
				end
				ST_WRITE: begin
					done_q        <= 1'b1;
					verdict_q     <= prl_pkg::VERDICT_KNOWN;
					blocked_now_q <= blk_q;
					slot_out_q    <= prl_pkg::SLOT_W'(slot_q);
					state_q       <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign verdict     = verdict_q;
	assign blocked_now = blocked_now_q;
	assign entry_slot  = slot_out_q;

endmodule

@@ design/per_source_packet_rate_limiter_unit.sv @@
`timescale 1ns / 1ps

// Per-source packet rate limiter. A request is taken when start is high and busy is low;
// command selects a packet (looked up by src_addr) or a one-tick advance of the time base.
// A tick leaves busy low and gives no result. A packet walks the source table one entry
// per cycle through a single address comparator on a registered memory read, then runs
// its window and block checks on one shared 32-bit adder. The result appears on verdict,
// blocked_now and entry_slot for exactly one cycle with done high; there is no back
// pressure, so the receiver must take it then. Table entries are never freed; once full,
// new sources are passed untracked. The user must see that configuration is written only
// while busy is low; the block itself does not enforce it.
module per_source_packet_rate_limiter_unit #(
	parameter int TABLE_ENTRIES = prl_pkg::TABLE_ENTRIES_DEF,
	localparam int IW = $clog2(TABLE_ENTRIES)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        command,
	input  logic [31:0]                 src_addr,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [prl_pkg::SPAN_W-1:0]  cfg_wdata,
	output logic                        done,
	output logic [1:0]                  verdict,
	output logic                        blocked_now,
	output logic [prl_pkg::SLOT_W-1:0]  entry_slot
);

	prl_pkg::cfg_t               cfg_q;
	prl_pkg::mem_ctl_t           mem_ctl;
	logic [IW-1:0]               mem_waddr;
	logic [IW-1:0]               mem_raddr;
	prl_pkg::entry_t             mem_wdata;
	prl_pkg::entry_t             mem_rdata;
	logic [prl_pkg::TIME_W-1:0]  alu_a;
	logic [prl_pkg::TIME_W-1:0]  alu_b;
	logic                        alu_sub;
	logic [prl_pkg::TIME_W-1:0]  alu_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.count_threshold <= prl_pkg::THRESHOLD_RST;
			cfg_q.window_ticks    <= prl_pkg::WINDOW_RST;
			cfg_q.block_ticks     <= prl_pkg::BLOCK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				prl_pkg::REG_THRESHOLD: cfg_q.count_threshold <= cfg_wdata[prl_pkg::CNT_W-1:0];
				prl_pkg::REG_WINDOW:    cfg_q.window_ticks    <= cfg_wdata;
				prl_pkg::REG_BLOCK:     cfg_q.block_ticks     <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	prl_seq #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.command     (command),
		.src_addr    (src_addr),
		.cfg         (cfg_q),
		.busy        (busy),
		.done        (done),
		.verdict     (verdict),
		.blocked_now (blocked_now),
		.entry_slot  (entry_slot),
		.mem_ctl     (mem_ctl),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata),
		.alu_a       (alu_a),
		.alu_b       (alu_b),
		.alu_sub     (alu_sub),
		.alu_sum     (alu_sum)
	);

	prl_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.ctl   (mem_ctl),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	prl_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.sum (alu_sum)
	);

endmodule

@@ design/prl_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module prl_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        command,
	input logic                        done,
	input logic [1:0]                  verdict,
	input logic                        blocked_now,
	input logic [prl_pkg::SLOT_W-1:0]  entry_slot
);

	// a result always lands back in idle
	`PRL_ASSERT_ALWAYS(a_done_idle, done |-> !busy, "result shown while busy")

	// a packet request starts a lookup, a tick request never gives a result
	`PRL_ASSERT(a_pkt_busy, (start && !busy && command == prl_pkg::CMD_PACKET) |=> busy, "packet request did not start a lookup")
	`PRL_ASSERT(a_tick_quiet, (start && !busy && command == prl_pkg::CMD_TICK) |=> (!busy && !done), "tick request gave a result")

	// only an accepted known source can become blocked
	`PRL_ASSERT(a_block_known, (done && blocked_now) |-> (verdict == prl_pkg::VERDICT_KNOWN), "block raised on a packet that was not accepted as known")

	`PRL_ASSERT(a_full_slot, (done && verdict == prl_pkg::VERDICT_FULL) |-> (entry_slot == '0), "untracked packet reported a slot")

endmodule

bind per_source_packet_rate_limiter_unit prl_checker u_prl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.command     (command),
	.done        (done),
	.verdict     (verdict),
	.blocked_now (blocked_now),
	.entry_slot  (entry_slot)
);
